/* rtl/xytp_pkg.sv */
package xytp_pkg;

  localparam int TRAIL_LENGTH = 256;
  localparam int TRAIL_AW     = $clog2(TRAIL_LENGTH);
  localparam int QUANT_SHIFT  = 9;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = SAMPLE_W - QUANT_SHIFT;
  localparam int OFFSET_W     = 9;
  localparam int COORD_W      = 11;
  localparam int COLOR_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [OFFSET_W-1:0] X_OFFSET_RST   = OFFSET_W'(64);
  localparam logic [OFFSET_W-1:0] Y_OFFSET_RST   = OFFSET_W'(64);
  localparam logic [COLOR_W-1:0]  TRACE_COLOR_RST = COLOR_W'(16'hFFFF);
  localparam logic [COLOR_W-1:0]  BG_COLOR_RST    = COLOR_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET         = 2'd0,
    REG_Y_OFFSET         = 2'd1,
    REG_TRACE_COLOR      = 2'd2,
    REG_BACKGROUND_COLOR = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] x_offset;
    logic [OFFSET_W-1:0] y_offset;
    logic [COLOR_W-1:0]  trace_color;
    logic [COLOR_W-1:0]  background_color;
  } cfg_t;

  // Ring entry; x sits in the low bits.
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  // New trace point handed from the ring controller to the output stage.
  typedef struct packed {
    logic   load;
    logic   erase;
    point_t pt;
  } draw_t;

  typedef struct packed {
    logic                we;
    logic [TRAIL_AW-1:0] waddr;
    point_t              wdata;
    logic                re;
    logic [TRAIL_AW-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/xytp_ram.sv */
module xytp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/xytp_ctrl.sv */
module xytp_ctrl
  import xytp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                s_tvalid,
  input  logic [31:0]         s_tdata,
  input  logic                s_tuser,
  input  logic                room,
  output logic                s_tready,
  output draw_t               cmd,
  output ram_req_t            ram_req
);

  logic [TRAIL_AW-1:0] head;
  logic [TRAIL_AW-1:0] tail;
  logic [TRAIL_AW-1:0] count;
  logic [LEVEL_W-1:0]  prev_x;
  logic [LEVEL_W-1:0]  prev_y;

  logic [LEVEL_W-1:0]  qx;
  logic [LEVEL_W-1:0]  qy;
  logic                accept;
  logic                draw;
  logic                full;
  point_t              pt;

  function automatic logic [TRAIL_AW-1:0] ring_inc(input logic [TRAIL_AW-1:0] idx);
    if (idx == TRAIL_AW'(TRAIL_LENGTH - 1)) begin
      return '0;
    end
    return idx + TRAIL_AW'(1);
  endfunction

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  // An arithmetic shift right keeps the top bits of each sample.
  assign qx = s_tdata[SAMPLE_W-1:QUANT_SHIFT];
  assign qy = s_tdata[2*SAMPLE_W-1:SAMPLE_W+QUANT_SHIFT];

  assign draw = (count == '0) || (s_tuser && ((qx != prev_x) || (qy != prev_y)));
  // The ring holds at most TRAIL_LENGTH-1 points between items.
  assign full = (count == TRAIL_AW'(TRAIL_LENGTH - 1));

  assign pt.x = {{(COORD_W-OFFSET_W){1'b0}}, cfg.x_offset}
              - {{(COORD_W-LEVEL_W){qx[LEVEL_W-1]}}, qx};
  assign pt.y = {{(COORD_W-OFFSET_W){1'b0}}, cfg.y_offset}
              - {{(COORD_W-LEVEL_W){qy[LEVEL_W-1]}}, qy};

  assign cmd.load  = accept && draw;
  assign cmd.erase = full;
  assign cmd.pt    = pt;

  // The tail slot never equals the head slot written in the same cycle,
  // and earlier writes are already in the array, so no forwarding is needed.
  assign ram_req.we    = accept && draw;
  assign ram_req.waddr = head;
  assign ram_req.wdata = pt;
  assign ram_req.re    = accept && draw && full;
  assign ram_req.raddr = tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else if (accept) begin
      prev_x <= qx;
      prev_y <= qy;
      if (draw) begin
        head <= ring_inc(head);
        if (full) begin
          tail <= ring_inc(tail);
        end else begin
          count <= count + TRAIL_AW'(1);
        end
      end
    end
  end

endmodule

/* rtl/xytp_out.sv */
module xytp_out
  import xytp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  draw_t       cmd,
  input  point_t      rdata,
  output logic        room,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  typedef enum logic [1:0] {
    PH_DRAW  = 2'b01,
    PH_ERASE = 2'b10
  } phase_t;

  logic               p_valid;
  logic               p_erase;
  phase_t             phase;
  point_t             p_pt;

  logic               m_valid;
  point_t             m_pt;
  logic [COLOR_W-1:0] m_color;
  logic               m_erase;
  logic               m_last;

  logic               out_load;
  logic               p_done;

  assign out_load = p_valid && (!m_valid || m_tready);
  assign p_done   = out_load && ((phase == PH_ERASE) || !p_erase);
  assign room     = !p_valid || p_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      phase   <= PH_DRAW;
      m_valid <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
      if (cmd.load) begin
        p_valid <= 1'b1;
        phase   <= PH_DRAW;
      end else if (p_done) begin
        p_valid <= 1'b0;
        phase   <= PH_DRAW;
      end else if (out_load) begin
        phase <= PH_ERASE;
      end
    end
  end

  // The ring read data holds until the next read, which only comes with
  // the next accepted item, after the erase has left this stage.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_pt    <= cmd.pt;
      p_erase <= cmd.erase;
    end
    if (out_load) begin
      unique case (phase)
        PH_DRAW: begin
          m_pt    <= p_pt;
          m_color <= cfg.trace_color;
          m_erase <= 1'b0;
          m_last  <= !p_erase;
        end
        PH_ERASE: begin
          m_pt    <= rdata;
          m_color <= cfg.background_color;
          m_erase <= 1'b1;
          m_last  <= 1'b1;
        end
        default: begin
          m_pt    <= p_pt;
          m_color <= cfg.trace_color;
          m_erase <= 1'b0;
          m_last  <= 1'b1;
        end
      endcase
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {2'b00, m_color, m_pt.y, m_pt.x};
  assign m_tuser  = m_erase;
  assign m_tlast  = m_last;

endmodule

/* rtl/xy_trace_pixel_trail.sv */
// The first result of an item passes through a pending register, then the output register,
// before it is on m_tvalid.
// Throughput: one item per cycle when it paints one pixel and m_tready stays high; an item
// that also erases the oldest point sends its draw and then its erase through the single output register.
// Reset (rst, synchronous): empties the trail, clears the remembered levels and
// loads the register defaults; ring contents are left as they are, with no clearing pass.
module xy_trace_pixel_trail
  import xytp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // x_sample[15:0], y_sample[31:16]
  input  logic                  s_tuser,   // compare_valid
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // pixel_x[10:0], pixel_y[21:11],
                                           // paint_color[37:22], zero[39:38]
  output logic                  m_tuser,   // is_erase
  output logic                  m_tlast    // last
);

  cfg_t     cfg;
  draw_t    cmd;
  ram_req_t ram_req;
  point_t   rdata;
  logic     room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset         <= X_OFFSET_RST;
      cfg.y_offset         <= Y_OFFSET_RST;
      cfg.trace_color      <= TRACE_COLOR_RST;
      cfg.background_color <= BG_COLOR_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_X_OFFSET:         cfg.x_offset         <= cfg_data[OFFSET_W-1:0];
        REG_Y_OFFSET:         cfg.y_offset         <= cfg_data[OFFSET_W-1:0];
        REG_TRACE_COLOR:      cfg.trace_color      <= cfg_data[COLOR_W-1:0];
        REG_BACKGROUND_COLOR: cfg.background_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  xytp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .room     (room),
    .s_tready (s_tready),
    .cmd      (cmd),
    .ram_req  (ram_req)
  );

  xytp_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TRAIL_LENGTH)
  ) u_trail (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  xytp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .rdata    (rdata),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/xytp_checker.sv */
module xytp_checker
  import xytp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [39:0]           m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // A stalled result transaction keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // An erase always closes the commands of its item.
  a_erase_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("erase command without last");

  // A draw that is not last is followed at once by its erase.
  a_erase_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser)
    else $error("missing erase after non-last draw");

  // A result stream that starts from idle traces back to an accepted input.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without input transaction");

endmodule

bind xy_trace_pixel_trail xytp_checker u_xytp_checker (.*);
